// ----- src/marseq_pkg.sv -----
package marseq_pkg;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_RAMP  = 3'd1,
    MODE_HOLD  = 3'd2,
    MODE_READY = 3'd3,
    MODE_STOP  = 3'd4,
    MODE_ERROR = 3'd5
  } mode_t;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  localparam cfg_index_t REG_ALIGN_CURRENT_MAX  = 3'd0;
  localparam cfg_index_t REG_ALIGN_CURRENT_STEP = 3'd1;
  localparam cfg_index_t REG_ANGLE_STEP         = 3'd2;
  localparam cfg_index_t REG_ANGLE_START        = 3'd3;
  localparam cfg_index_t REG_HOLD_TICKS         = 3'd4;
  localparam cfg_index_t REG_TIMEOUT_LIMIT      = 3'd5;

  localparam logic [15:0] ALIGN_CURRENT_MAX_RST  = 16'd16384;
  localparam logic [15:0] ALIGN_CURRENT_STEP_RST = 16'd16;
  localparam logic [15:0] ANGLE_STEP_RST         = 16'd8;
  localparam logic [15:0] ANGLE_START_RST        = 16'd0;
  localparam logic [31:0] HOLD_TICKS_RST         = 32'd80000;
  localparam logic [15:0] TIMEOUT_LIMIT_RST      = 16'd0;

  // error bit positions
  localparam int unsigned ERR_DRIVER   = 0;
  localparam int unsigned ERR_ROLLOVER = 1;
  localparam int unsigned ERR_TIMEOUT  = 2;
  localparam int unsigned ERR_INDEX    = 3;

  typedef struct packed {
    logic [15:0] align_current_max;
    logic [15:0] align_current_step;
    logic [15:0] angle_step;
    logic [31:0] hold_ticks;
    logic [15:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] d_ref;
    logic [31:0] tick;
    logic [15:0] angle;
  } state_t;

  typedef struct packed {
    logic        motor_enable;
    logic        system_enable;
    logic        driver_fault_pin;
    logic        rollover_error;
    logic        rollover_check;
    logic [15:0] timeout_count;
    logic        index_seen;
    logic        index_bad;
  } cmd_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  error_bits;
    logic [15:0] d_current_ref;
    logic        q_from_position_loop;
    logic        drive_active;
    logic        angle_override_valid;
    logic [15:0] forced_angle;
    logic        encoder_reset;
    logic        controller_reset;
    logic [31:0] tick_count;
  } result_t;

endpackage

// ----- src/marseq_fsm.sv -----
module marseq_fsm (
  input  marseq_pkg::cfg_t    cfg,
  input  marseq_pkg::state_t  cur,
  input  marseq_pkg::cmd_t    cmd,
  output marseq_pkg::state_t  nxt,
  output marseq_pkg::result_t res
);
  import marseq_pkg::*;

  logic [3:0]  err;
  mode_t       eff_mode;
  logic [16:0] ramp_sum;
  logic [15:0] ramp_sat;
  logic [31:0] tick_inc;

  always_comb begin
    err = '0;
    err[ERR_DRIVER]   = !cmd.driver_fault_pin;
    err[ERR_ROLLOVER] = cmd.rollover_error && cmd.rollover_check;
    err[ERR_TIMEOUT]  = (cfg.timeout_limit != 16'd0) && (cmd.timeout_count > cfg.timeout_limit);
    err[ERR_INDEX]    = cmd.index_seen && cmd.index_bad;
    eff_mode = (err != 4'd0) ? MODE_ERROR : cur.mode;
  end

  assign ramp_sum = {1'b0, cur.d_ref} + {1'b0, cfg.align_current_step};
  assign ramp_sat = ramp_sum[16] ? 16'hFFFF : ramp_sum[15:0];
  assign tick_inc = cur.tick + 32'd1;

  // next state
  always_comb begin
    nxt = cur;
    unique case (eff_mode)
      MODE_RAMP: begin
        nxt.tick  = '0;
        nxt.d_ref = ramp_sat;
        nxt.angle = cur.angle - cfg.angle_step;
        if (!cmd.motor_enable || !cmd.system_enable) begin
          nxt.mode = MODE_INIT;
        end else if (ramp_sat < cfg.align_current_max) begin
          nxt.mode = MODE_RAMP;
        end else begin
          nxt.mode = MODE_HOLD;
        end
      end
      MODE_HOLD: begin
        nxt.tick  = tick_inc;
        nxt.d_ref = cfg.align_current_max;
        if (!cmd.motor_enable || !cmd.system_enable) begin
          nxt.mode = MODE_INIT;
        end else if (tick_inc < cfg.hold_ticks) begin
          nxt.mode = MODE_HOLD;
        end else begin
          nxt.mode = MODE_READY;
        end
      end
      MODE_READY, MODE_STOP: begin
        nxt.tick  = tick_inc;
        nxt.d_ref = '0;
        if (!cmd.system_enable) begin
          nxt.mode = MODE_INIT;
        end else if (cmd.motor_enable) begin
          nxt.mode = MODE_READY;
        end else begin
          nxt.mode = MODE_STOP;
        end
      end
      MODE_ERROR: begin
        nxt.d_ref = '0;
        nxt.mode  = MODE_ERROR;
      end
      default: begin
        nxt.tick  = '0;
        nxt.d_ref = '0;
        nxt.mode  = (cmd.motor_enable && cmd.system_enable) ? MODE_RAMP : MODE_INIT;
      end
    endcase
  end

  // outputs
  always_comb begin
    res = '0;
    res.mode          = nxt.mode;
    res.error_bits    = err;
    res.d_current_ref = nxt.d_ref;
    res.forced_angle  = nxt.angle;
    res.tick_count    = nxt.tick;
    unique case (eff_mode)
      MODE_RAMP: begin
        res.drive_active         = 1'b1;
        res.angle_override_valid = (nxt.mode == MODE_RAMP);
        res.encoder_reset        = (nxt.mode != MODE_RAMP);
      end
      MODE_HOLD: begin
        res.drive_active  = 1'b1;
        res.encoder_reset = 1'b1;
      end
      MODE_READY: begin
        res.drive_active         = 1'b1;
        res.q_from_position_loop = 1'b1;
      end
      MODE_STOP: begin
        res.drive_active = 1'b1;
      end
      MODE_ERROR: begin
        res.drive_active = 1'b0;
      end
      default: begin
        res.encoder_reset    = 1'b1;
        res.controller_reset = 1'b1;
      end
    endcase
  end

endmodule

// ----- src/motor_align_run_sequencer_core.sv -----
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       enable bits, fault inputs, timeout_count
// out       output     out_valid / out_ready     mode, error_bits, references, strobes, tick_count
// cfg       input      cfg_write                 cfg_index, cfg_data (32 bits)
//
// one tick per cycle while the output is not stalled: the sequencer state and the result register
// update at the same edge the tick is taken, so the result shows in the cycle after the transfer
// in_ready is high while the result register is empty or being drained this cycle
// a stalled output holds the result and blocks new ticks; nothing is dropped
// rst is synchronous: mode init, references zero, config registers to their defaults
module motor_align_run_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        motor_enable,
  input  logic        system_enable,
  input  logic        driver_fault_pin,
  input  logic        rollover_error,
  input  logic        rollover_check,
  input  logic [15:0] timeout_count,
  input  logic        index_seen,
  input  logic        index_bad,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  mode,
  output logic [3:0]  error_bits,
  output logic [15:0] d_current_ref,
  output logic        q_from_position_loop,
  output logic        drive_active,
  output logic        angle_override_valid,
  output logic [15:0] forced_angle,
  output logic        encoder_reset,
  output logic        controller_reset,
  output logic [31:0] tick_count
);
  import marseq_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  cmd_t    cmd;
  result_t res_next;
  result_t res;
  logic    in_accept;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign cmd.motor_enable     = motor_enable;
  assign cmd.system_enable    = system_enable;
  assign cmd.driver_fault_pin = driver_fault_pin;
  assign cmd.rollover_error   = rollover_error;
  assign cmd.rollover_check   = rollover_check;
  assign cmd.timeout_count    = timeout_count;
  assign cmd.index_seen       = index_seen;
  assign cmd.index_bad        = index_bad;

  marseq_fsm u_fsm (
    .cfg (cfg),
    .cur (state),
    .cmd (cmd),
    .nxt (state_next),
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.align_current_max  <= ALIGN_CURRENT_MAX_RST;
      cfg.align_current_step <= ALIGN_CURRENT_STEP_RST;
      cfg.angle_step         <= ANGLE_STEP_RST;
      cfg.hold_ticks         <= HOLD_TICKS_RST;
      cfg.timeout_limit      <= TIMEOUT_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ALIGN_CURRENT_MAX:  cfg.align_current_max  <= cfg_data[15:0];
        REG_ALIGN_CURRENT_STEP: cfg.align_current_step <= cfg_data[15:0];
        REG_ANGLE_STEP:         cfg.angle_step         <= cfg_data[15:0];
        REG_HOLD_TICKS:         cfg.hold_ticks         <= cfg_data;
        REG_TIMEOUT_LIMIT:      cfg.timeout_limit      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // writing the start angle also reloads the forced angle
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode  <= MODE_INIT;
      state.d_ref <= '0;
      state.tick  <= '0;
      state.angle <= ANGLE_START_RST;
    end else if (cfg_write && (cfg_index == REG_ANGLE_START)) begin
      state.angle <= cfg_data[15:0];
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res <= res_next;
    end
  end

  assign mode                 = res.mode;
  assign error_bits           = res.error_bits;
  assign d_current_ref        = res.d_current_ref;
  assign q_from_position_loop = res.q_from_position_loop;
  assign drive_active         = res.drive_active;
  assign angle_override_valid = res.angle_override_valid;
  assign forced_angle         = res.forced_angle;
  assign encoder_reset        = res.encoder_reset;
  assign controller_reset     = res.controller_reset;
  assign tick_count           = res.tick_count;

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    state.mode == MODE_ERROR |=> state.mode == MODE_ERROR)
    else $error("sequencer left the error state");

  a_fault_to_error: assert property (@(posedge clk) disable iff (rst)
    in_accept && !driver_fault_pin |=> out_valid && mode == MODE_ERROR && error_bits[ERR_DRIVER])
    else $error("driver fault did not reach the error state");

  a_ctl_reset_in_init: assert property (@(posedge clk) disable iff (rst)
    out_valid && controller_reset |-> encoder_reset && !drive_active && !q_from_position_loop)
    else $error("controller reset outside init behavior");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("empty result register refused a tick");

endmodule
